// ===== sv/rover_command_drive_controller_unit_defines.svh =====
// Assertion macros used by the rover drive controller checker.
`ifndef ROVER_COMMAND_DRIVE_CONTROLLER_UNIT_DEFINES_SVH
`define ROVER_COMMAND_DRIVE_CONTROLLER_UNIT_DEFINES_SVH

// Concurrent assertion on a given clock, disabled while the reset is low.
`define RCDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same check on the standard clock and reset port names.
`define RCDC_ASSERT_CLK(label, prop, msg) \
    `RCDC_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== sv/rcdc_pkg.sv =====
// Types, codes and constants of the rover drive controller.
package rcdc_pkg;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int DIST_W   = 10;
    localparam int DIR_W    = 3;
    localparam int SPEED_W  = 7;
    localparam int CUE_W    = 3;
    localparam int MEV_W    = 2;
    localparam int AGE_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Event kinds.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_CMD   = 2'd1,
        FUNC_RANGE = 2'd2
    } t_func;

    // Drive directions, also used as motor commands.
    typedef enum logic [DIR_W-1:0] {
        DIR_STOP   = 3'd0,
        DIR_FWD    = 3'd1,
        DIR_BACK   = 3'd2,
        DIR_TURN_L = 3'd3,
        DIR_TURN_R = 3'd4
    } t_dir;

    // Buzzer cues.
    typedef enum logic [CUE_W-1:0] {
        CUE_NONE        = 3'd0,
        CUE_ALERT       = 3'd1,
        CUE_STARTUP     = 3'd2,
        CUE_MODE_SWITCH = 3'd3,
        CUE_REVERSE     = 3'd4
    } t_cue;

    // Mode change events.
    typedef enum logic [MEV_W-1:0] {
        MEV_NONE     = 2'd0,
        MEV_AUTONOMY = 2'd1,
        MEV_MANUAL   = 2'd2
    } t_mev;

    // Drive modes.
    typedef enum logic {
        MODE_MANUAL = 1'b0,
        MODE_AUTO   = 1'b1
    } t_mode;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_STOP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_TIMEOUT  = 1'd1;

    // Reset values and fixed numbers.
    localparam logic [DIST_W-1:0]  SAFETY_STOP_RESET = 10'd20;
    localparam logic [AGE_W-1:0]   HB_TIMEOUT_RESET  = 8'd20;
    localparam logic [SPEED_W-1:0] SPEED_RESET       = 7'd50;
    localparam logic [SPEED_W-1:0] SPEED_STEP        = 7'd10;
    localparam logic [SPEED_W-1:0] SPEED_PLUS_LIMIT  = 7'd90;
    localparam logic [SPEED_W-1:0] SPEED_FULL        = 7'd100;
    localparam logic [DIST_W-1:0]  DIST_RESET        = 10'd400;

    // Command characters.
    localparam logic [BYTE_W-1:0] CASE_MASK = 8'hDF;
    localparam logic [BYTE_W-1:0] CH_F      = "F";
    localparam logic [BYTE_W-1:0] CH_M      = "M";
    localparam logic [BYTE_W-1:0] CH_W      = "W";
    localparam logic [BYTE_W-1:0] CH_S      = "S";
    localparam logic [BYTE_W-1:0] CH_A      = "A";
    localparam logic [BYTE_W-1:0] CH_Q      = "Q";
    localparam logic [BYTE_W-1:0] CH_D      = "D";
    localparam logic [BYTE_W-1:0] CH_E      = "E";
    localparam logic [BYTE_W-1:0] CH_P      = "P";
    localparam logic [BYTE_W-1:0] CH_PLUS   = "+";
    localparam logic [BYTE_W-1:0] CH_MINUS  = "-";
    localparam logic [BYTE_W-1:0] CH_0      = "0";
    localparam logic [BYTE_W-1:0] CH_9      = "9";

    // One input event.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] cmd_byte;
        logic [DIST_W-1:0] range_cm;
    } t_in_item;

    // Configuration registers.
    typedef struct packed {
        logic [DIST_W-1:0] safety_stop_cm;
        logic [AGE_W-1:0]  hb_timeout;
    } t_cfg;

    // Controller state.
    typedef struct packed {
        t_mode              mode;
        t_dir               dir;
        logic [SPEED_W-1:0] speed;
        logic [AGE_W-1:0]   age;
        logic [DIST_W-1:0]  last_cm;
    } t_state;

    // One result.
    typedef struct packed {
        logic               motor_valid;
        t_dir               motor_cmd;
        logic [SPEED_W-1:0] motor_speed;
        t_cue               buzzer_cue;
        t_mev               mode_event;
        t_mode              mode_now;
        t_dir               direction_now;
    } t_result;

endpackage

// ===== sv/rcdc_in_if.sv =====
// Event channel of the rover drive controller.
interface rcdc_in_if import rcdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] cmd_byte;
    logic [DIST_W-1:0] range_cm;

    modport source (output valid, func, cmd_byte, range_cm, input ready);
    modport sink   (input valid, func, cmd_byte, range_cm, output ready);
endinterface

// ===== sv/rcdc_out_if.sv =====
// Result channel of the rover drive controller.
interface rcdc_out_if import rcdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               motor_valid;
    logic [DIR_W-1:0]   motor_cmd;
    logic [SPEED_W-1:0] motor_speed;
    logic [CUE_W-1:0]   buzzer_cue;
    logic [MEV_W-1:0]   mode_event;
    logic               mode_now;
    logic [DIR_W-1:0]   direction_now;

    modport source (output valid, motor_valid, motor_cmd, motor_speed, buzzer_cue,
                    mode_event, mode_now, direction_now, input ready);
    modport sink   (input valid, motor_valid, motor_cmd, motor_speed, buzzer_cue,
                    mode_event, mode_now, direction_now, output ready);
endinterface

// ===== sv/rcdc_step.sv =====
// Single-event step logic: next controller state and the result of one event.
module rcdc_step import rcdc_pkg::*; (
    input  t_state   i_state,
    input  t_cfg     i_cfg,
    input  t_in_item i_item,
    output t_state   o_state,
    output t_result  o_res
);

    always_comb begin
        t_state             s;
        t_result            r;
        logic               run_hb;
        logic               speed_change;
        logic               fwd_blocked;
        logic               is_digit;
        logic [BYTE_W-1:0]  upper;
        logic [SPEED_W-1:0] digit_speed;

        s            = i_state;
        r            = '0;
        run_hb       = 1'b0;
        speed_change = 1'b0;
        upper        = i_item.cmd_byte & CASE_MASK;
        is_digit     = (i_item.cmd_byte >= CH_0) && (i_item.cmd_byte <= CH_9);
        digit_speed  = (i_item.cmd_byte[3:0] == 4'd0) ? SPEED_FULL
                     : 7'(7'(i_item.cmd_byte[3:0]) * SPEED_STEP);
        // The distance does not change on a command event.
        fwd_blocked  = (i_state.last_cm == '0) || (i_state.last_cm <= i_cfg.safety_stop_cm);

        case (i_item.func)
            FUNC_TICK: begin
                run_hb = 1'b1;
            end
            FUNC_CMD: begin
                s.age  = '0;
                run_hb = 1'b1;
                if (upper == CH_F) begin
                    // Enter autonomy mode and stop.
                    s.mode        = MODE_AUTO;
                    s.dir         = DIR_STOP;
                    r.motor_valid = 1'b1;
                    r.buzzer_cue  = CUE_STARTUP;
                    r.mode_event  = MEV_AUTONOMY;
                    run_hb        = 1'b0;
                end else if (upper == CH_M) begin
                    // Enter manual mode and stop.
                    s.mode        = MODE_MANUAL;
                    s.dir         = DIR_STOP;
                    r.motor_valid = 1'b1;
                    r.buzzer_cue  = CUE_MODE_SWITCH;
                    r.mode_event  = MEV_MANUAL;
                    run_hb        = 1'b0;
                end else begin
                    if (is_digit) begin
                        s.speed      = digit_speed;
                        speed_change = 1'b1;
                    end
                    // Motion and speed step commands.
                    case (upper)
                        CH_W: begin
                            r.motor_valid = 1'b1;
                            if (fwd_blocked) begin
                                s.dir        = DIR_STOP;
                                r.buzzer_cue = CUE_ALERT;
                            end else begin
                                s.dir         = DIR_FWD;
                                r.motor_cmd   = DIR_FWD;
                                r.motor_speed = s.speed;
                            end
                        end
                        CH_S: begin
                            s.dir         = DIR_BACK;
                            r.motor_valid = 1'b1;
                            r.motor_cmd   = DIR_BACK;
                            r.motor_speed = s.speed;
                            r.buzzer_cue  = CUE_REVERSE;
                        end
                        CH_A, CH_Q: begin
                            s.dir         = DIR_TURN_L;
                            r.motor_valid = 1'b1;
                            r.motor_cmd   = DIR_TURN_L;
                            r.motor_speed = s.speed;
                        end
                        CH_D, CH_E: begin
                            s.dir         = DIR_TURN_R;
                            r.motor_valid = 1'b1;
                            r.motor_cmd   = DIR_TURN_R;
                            r.motor_speed = s.speed;
                        end
                        CH_P: begin
                            s.dir         = DIR_STOP;
                            r.motor_valid = 1'b1;
                        end
                        default: begin
                            if (i_item.cmd_byte == CH_PLUS) begin
                                if (s.speed <= SPEED_PLUS_LIMIT) begin
                                    s.speed = s.speed + SPEED_STEP;
                                end
                                speed_change = 1'b1;
                            end else if (i_item.cmd_byte == CH_MINUS) begin
                                if (s.speed >= SPEED_STEP) begin
                                    s.speed = s.speed - SPEED_STEP;
                                end
                                speed_change = 1'b1;
                            end
                        end
                    endcase
                    // Reissue the current motion at the new speed, or stop with an alert if forward is blocked.
                    if (speed_change && (s.dir != DIR_STOP)) begin
                        r.motor_valid = 1'b1;
                        if ((s.dir == DIR_FWD) && fwd_blocked) begin
                            s.dir         = DIR_STOP;
                            r.motor_cmd   = DIR_STOP;
                            r.motor_speed = '0;
                            r.buzzer_cue  = CUE_ALERT;
                            run_hb        = 1'b0;
                        end else begin
                            r.motor_cmd   = s.dir;
                            r.motor_speed = s.speed;
                        end
                    end
                end
            end
            FUNC_RANGE: begin
                // A zero sample reads as the far default distance.
                s.last_cm = (i_item.range_cm == '0) ? DIST_RESET : i_item.range_cm;
                if (s.last_cm <= i_cfg.safety_stop_cm) begin
                    s.dir         = DIR_STOP;
                    r.motor_valid = 1'b1;
                    r.motor_cmd   = DIR_STOP;
                    r.motor_speed = '0;
                end
            end
            default: begin
            end
        endcase

        // Heartbeat: in autonomy mode the drive stops once commands go stale.
        if (run_hb && (s.mode == MODE_AUTO)) begin
            if (s.age < i_cfg.hb_timeout) begin
                s.age = s.age + 8'd1;
            end
            if (s.age >= i_cfg.hb_timeout) begin
                s.dir         = DIR_STOP;
                r.motor_valid = 1'b1;
                r.motor_cmd   = DIR_STOP;
                r.motor_speed = '0;
            end
        end

        r.mode_now      = s.mode;
        r.direction_now = s.dir;
        o_state         = s;
        o_res           = r;
    end

endmodule

// ===== sv/rover_command_drive_controller_unit.sv =====
// Rover command and drive controller top level. It takes one event beat per clock cycle while
// the result channel is not stalled, and gives one result beat per event. An accepted event is
// held in the input register, the step logic computes the result and the next controller state
// from it, and both are written together into the result register, which offers the result,
// and the state register, so the following event already sees the updated state. The
// combinational step from the input register to the result register sets the rate of one
// event per cycle; a stalled result holds one further event in the input register.
// Configuration writes take effect at the next edge and are meant for times when no event is
// in flight.
module rover_command_drive_controller_unit import rcdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rcdc_in_if.sink               i_in,
    rcdc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic     r_in_valid;
    t_in_item r_in;
    logic     r_out_valid;
    t_result  r_res;
    t_state   r_state;
    t_cfg     r_cfg;

    logic     w_adv;
    logic     w_in_ready;
    t_state   n_state;
    t_result  n_res;

    // The input register moves on when the result register is free or drained.
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = i_rst_n && (!r_in_valid || w_adv);
    assign i_in.ready = w_in_ready;

    rcdc_step u_rcdc_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.safety_stop_cm <= SAFETY_STOP_RESET;
            r_cfg.hb_timeout     <= HB_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAFETY_STOP: r_cfg.safety_stop_cm <= i_cfg_wdata;
                CFG_HB_TIMEOUT:  r_cfg.hb_timeout     <= i_cfg_wdata[AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in.func     <= i_in.func;
            r_in.cmd_byte <= i_in.cmd_byte;
            r_in.range_cm <= i_in.range_cm;
        end
    end

    // Controller state, updated as each event is stepped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= MODE_MANUAL;
            r_state.dir     <= DIR_STOP;
            r_state.speed   <= SPEED_RESET;
            r_state.age     <= HB_TIMEOUT_RESET;
            r_state.last_cm <= DIST_RESET;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.motor_valid   = r_res.motor_valid;
    assign o_out.motor_cmd     = r_res.motor_cmd;
    assign o_out.motor_speed   = r_res.motor_speed;
    assign o_out.buzzer_cue    = r_res.buzzer_cue;
    assign o_out.mode_event    = r_res.mode_event;
    assign o_out.mode_now      = r_res.mode_now;
    assign o_out.direction_now = r_res.direction_now;

endmodule

// ===== sv/rcdc_checker.sv =====
// Port-level checker for the rover drive controller, bound to the top level.
`include "rover_command_drive_controller_unit_defines.svh"

module rcdc_checker import rcdc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_motor_valid,
    input logic [DIR_W-1:0]   i_motor_cmd,
    input logic [SPEED_W-1:0] i_motor_speed,
    input logic [MEV_W-1:0]   i_mode_event,
    input logic               i_mode_now,
    input logic [19:0]        i_out_payload
);

    logic r_last_mode;
    logic w_out_beat;

    assign w_out_beat = i_out_valid && i_out_ready;

    // Mode reported by the last delivered result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mode <= MODE_MANUAL;
        end else if (w_out_beat) begin
            r_last_mode <= i_mode_now;
        end
    end

    // A stalled result keeps its beat.
    `RCDC_ASSERT_CLK(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload), "result changed while stalled")

    // A result appears only once a taken event beat has passed the input and result registers.
    `RCDC_ASSERT_CLK(a_out_latency, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2), "result without a matching event")

    // Without a motor command the command fields read as zero.
    `RCDC_ASSERT_CLK(a_no_motor_zero, i_out_valid && !i_motor_valid |-> i_motor_cmd == DIR_STOP && i_motor_speed == '0, "motor fields set without a command")

    // The mode changes only with a mode event, and then to the announced mode.
    `RCDC_ASSERT_CLK(a_mode_track, w_out_beat |-> (i_mode_event == MEV_NONE && i_mode_now == r_last_mode) || (i_mode_event == MEV_AUTONOMY && i_mode_now == MODE_AUTO) || (i_mode_event == MEV_MANUAL && i_mode_now == MODE_MANUAL), "mode changed without a matching mode event")

endmodule

bind rover_command_drive_controller_unit rcdc_checker u_rcdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_motor_valid (o_out.motor_valid),
    .i_motor_cmd   (o_out.motor_cmd),
    .i_motor_speed (o_out.motor_speed),
    .i_mode_event  (o_out.mode_event),
    .i_mode_now    (o_out.mode_now),
    .i_out_payload ({o_out.motor_valid, o_out.motor_cmd, o_out.motor_speed,
                     o_out.buzzer_cue, o_out.mode_event, o_out.mode_now,
                     o_out.direction_now})
);
